### rtl/dop_pkg.sv
`timescale 1ns / 1ps

package dop_pkg;

    // Operation codes of an input item
    localparam logic [1:0] OP_BEGIN  = 2'd0;
    localparam logic [1:0] OP_HEADER = 2'd1;
    localparam logic [1:0] OP_DATA   = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_DROPPED  = 2'd2;
    localparam logic [1:0] ST_INVALID  = 2'd3;

    // Placement areas; the unused fourth code acts as the sname area
    localparam logic [1:0] AREA_OPTIONS = 2'd0;
    localparam logic [1:0] AREA_FILE    = 2'd1;
    localparam logic [1:0] AREA_SNAME   = 2'd2;

    // Configuration register indexes
    localparam logic REG_MAX_PACKET_SIZE   = 1'b0;
    localparam logic REG_OVERLOAD_SECTIONS = 1'b1;

    // Message layout
    localparam logic [15:0] OPT_START   = 16'd240;
    localparam logic [15:0] FILE_START  = 16'd108;
    localparam logic [15:0] FILE_SIZE   = 16'd128;
    localparam logic [15:0] SNAME_START = 16'd44;
    localparam logic [15:0] SNAME_SIZE  = 16'd64;
    localparam logic [15:0] COOKIE_ADDR = 16'd236;

    // Room needed besides the option data: code and length bytes plus OVERLOAD option and END, or plus just END
    localparam logic [8:0] OPT_AREA_RESERVE = 9'd6;
    localparam logic [8:0] OVL_AREA_RESERVE = 9'd3;

    localparam logic [7:0] CODE_PAD      = 8'd0;
    localparam logic [7:0] CODE_OVERLOAD = 8'd52;
    localparam logic [7:0] CODE_END      = 8'd255;

    localparam logic [7:0] COOKIE_0 = 8'h63;
    localparam logic [7:0] COOKIE_1 = 8'h82;
    localparam logic [7:0] COOKIE_2 = 8'h53;
    localparam logic [7:0] COOKIE_3 = 8'h63;

    localparam int MAX_RESULTS = 9;
    localparam int RES_CNT_W   = 4;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] option_code;
        logic [7:0] data_length;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic        write_valid;
        logic [15:0] write_address;
        logic [7:0]  write_value;
        logic [1:0]  status;
        logic        last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [15:0] cursor;
        logic [1:0]  area;
        logic [7:0]  bytes_left;
        logic        rejected;
    } place_state_t;

    typedef struct packed {
        logic [15:0] max_packet_size;
        logic [1:0]  overload_sections;
    } place_cfg_t;

    // True when the cursor lies inside the area and enough bytes remain for
    // an option of the given length plus its trailing reserve.
    function automatic logic area_fits(input logic [15:0] cur, input logic [15:0] start,
                                       input logic [15:0] size, input logic [7:0] len);
        logic [15:0] offset;
        logic [15:0] room;
        logic [15:0] need;
        offset = cur - start;
        room   = size - offset;
        need   = {7'd0, {1'b0, len} + OVL_AREA_RESERVE};
        if (cur < start || offset >= size) begin
            area_fits = 1'b0;
        end else begin
            area_fits = (room >= need);
        end
    endfunction

    function automatic out_item_t byte_write(input logic [15:0] addr, input logic [7:0] val);
        out_item_t r;
        r.write_valid   = 1'b1;
        r.write_address = addr;
        r.write_value   = val;
        r.status        = ST_OK;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    function automatic out_item_t no_write(input logic [1:0] st);
        out_item_t r;
        r.write_valid   = 1'b0;
        r.write_address = 16'd0;
        r.write_value   = 8'd0;
        r.status        = st;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

endpackage

### rtl/dhcp_option_placer_unit.sv
`timescale 1ns / 1ps

// DHCPv4 option placer.
// Input channel (s_valid/s_ready/s_data): one transfer per item, either a
// begin-message, an option header or one option data byte. Result channel
// (m_valid/m_ready/m_data): one transfer per byte write or status report,
// with last_of_run marking the final result of an item (0 to 9 per item; an unused operation gives none).
// Configuration: cfg_we/cfg_index/cfg_wdata write max_packet_size (index 0)
// or overload_sections (index 1); write only while the block is idle.
// An accepted item waits in the input register and is placed into the result
// buffer once the buffer is free; its results are offered from there.
// Throughput: one result transfer per cycle while m_ready is high. An item with
// a single result can follow every cycle while m_ready stays high; while an item
// with several results drains from the single result buffer, one entry per cycle,
// the next item waits in the input register.
// Reset (aresetn low, synchronous): empties both registers, restores the
// cursor to the options area start and clears both configuration registers.
// When the receiver stalls, the current result holds steady on m_data; one
// further item is taken into the input register and then s_ready drops.
module dhcp_option_placer_unit import dop_pkg::*; #(
    parameter int MIN_PACKET_SIZE = 576,
    parameter int HEADER_RESERVE  = 68
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,

    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    // Input register
    in_item_t     in_item_reg;
    logic         in_valid_reg;
    logic         in_valid_next;

    // Placement state and configuration
    place_state_t state_reg;
    place_state_t state_next;
    place_cfg_t   cfg_reg;
    place_cfg_t   cfg_next;

    // Result buffer: the whole run of one item, drained one entry per cycle while m_ready is high
    out_item_t            res_buf_reg [MAX_RESULTS];
    logic [RES_CNT_W-1:0] cnt_reg;
    logic [RES_CNT_W-1:0] cnt_next;
    logic [RES_CNT_W-1:0] idx_reg;
    logic [RES_CNT_W-1:0] idx_next;

    out_item_t            place_res [MAX_RESULTS];
    logic [RES_CNT_W-1:0] place_cnt;
    place_state_t         place_state;

    logic in_fire;
    logic out_fire;
    logic out_last;
    logic buf_free;
    logic take;
    logic load;

    dop_placer #(
        .MIN_PACKET_SIZE (MIN_PACKET_SIZE),
        .HEADER_RESERVE  (HEADER_RESERVE)
    ) u_placer (
        .item_i  (in_item_reg),
        .state_i (state_reg),
        .cfg_i   (cfg_reg),
        .res_o   (place_res),
        .count_o (place_cnt),
        .state_o (place_state)
    );

    assign m_valid  = (cnt_reg != '0);
    assign out_fire = m_valid && m_ready;
    assign out_last = (idx_reg == cnt_reg - 1'b1);
    // The buffer takes a new run once it is empty or its last entry leaves now
    assign buf_free = (cnt_reg == '0) || (out_fire && out_last);
    assign take     = in_valid_reg && buf_free;
    assign load     = take && (place_cnt != '0);
    assign s_ready  = !in_valid_reg || take;
    assign in_fire  = s_valid && s_ready;

    always_comb begin
        m_data             = res_buf_reg[idx_reg];
        m_data.last_of_run = out_last;
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_fire) begin
            in_valid_next = 1'b1;
        end else if (take) begin
            in_valid_next = 1'b0;
        end

        // Advance placement state only when the item leaves the input register
        state_next = take ? place_state : state_reg;

        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load) begin
            cnt_next = place_cnt;
            idx_next = '0;
        end else if (out_fire) begin
            if (out_last) begin
                cnt_next = '0;
                idx_next = '0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end

        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_MAX_PACKET_SIZE:   cfg_next.max_packet_size   = cfg_wdata;
                REG_OVERLOAD_SECTIONS: cfg_next.overload_sections = cfg_wdata[1:0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg         <= 1'b0;
            state_reg.cursor     <= OPT_START;
            state_reg.area       <= AREA_OPTIONS;
            state_reg.bytes_left <= 8'd0;
            state_reg.rejected   <= 1'b0;
            cfg_reg              <= '0;
            cnt_reg              <= '0;
            idx_reg              <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
            cfg_reg      <= cfg_next;
            cnt_reg      <= cnt_next;
            idx_reg      <= idx_next;
        end
    end

    // Payload registers: hold unless loaded
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_item_reg <= s_data;
        end
        if (load) begin
            res_buf_reg <= place_res;
        end
    end

endmodule

### rtl/dop_placer.sv
`timescale 1ns / 1ps

module dop_placer import dop_pkg::*; #(
    parameter int MIN_PACKET_SIZE = 576,
    parameter int HEADER_RESERVE  = 68
) (
    input  in_item_t              item_i,
    input  place_state_t          state_i,
    input  place_cfg_t            cfg_i,
    output out_item_t             res_o [MAX_RESULTS],
    output logic [RES_CNT_W-1:0]  count_o,
    output place_state_t          state_o
);

    localparam logic [15:0] MIN_SIZE  = 16'(MIN_PACKET_SIZE);
    localparam logic [15:0] RESERVE   = 16'(HEADER_RESERVE);
    localparam logic [15:0] LIM_FLOOR = 16'(MIN_PACKET_SIZE - HEADER_RESERVE);

    logic [15:0] limit;
    logic [15:0] opt_room;
    logic [15:0] opt_need;

    assign limit    = (cfg_i.max_packet_size > MIN_SIZE) ? cfg_i.max_packet_size - RESERVE
                                                         : LIM_FLOOR;
    assign opt_room = (limit > state_i.cursor) ? limit - state_i.cursor : 16'd0;
    assign opt_need = {7'd0, {1'b0, item_i.data_length} + OPT_AREA_RESERVE};

    always_comb begin
        logic [15:0]          cur;
        logic [1:0]           area;
        logic [7:0]           left;
        logic                 rej;
        logic                 fit;
        logic                 nospace;
        logic [1:0]           ov;
        logic [RES_CNT_W-1:0] n;

        cur     = state_i.cursor;
        area    = state_i.area;
        left    = state_i.bytes_left;
        rej     = state_i.rejected;
        fit     = 1'b0;
        nospace = 1'b0;
        ov      = cfg_i.overload_sections;
        n       = '0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            res_o[i] = no_write(ST_OK);
        end

        case (item_i.operation)
            OP_BEGIN: begin
                cur  = OPT_START;
                area = AREA_OPTIONS;
                left = 8'd0;
                rej  = 1'b0;
                res_o[0] = byte_write(COOKIE_ADDR,          COOKIE_0);
                res_o[1] = byte_write(COOKIE_ADDR + 16'd1,  COOKIE_1);
                res_o[2] = byte_write(COOKIE_ADDR + 16'd2,  COOKIE_2);
                res_o[3] = byte_write(COOKIE_ADDR + 16'd3,  COOKIE_3);
                res_o[4] = byte_write(OPT_START,            CODE_END);
                n = RES_CNT_W'(5);
            end
            OP_HEADER: begin
                if (item_i.option_code == CODE_PAD || item_i.option_code == CODE_OVERLOAD
                        || item_i.option_code == CODE_END) begin
                    rej  = 1'b1;
                    left = item_i.data_length;
                    res_o[0] = no_write(ST_INVALID);
                    n = RES_CNT_W'(1);
                end else begin
                    if (area == AREA_OPTIONS) begin
                        if (opt_room >= opt_need) begin
                            fit = 1'b1;
                        end else if (ov == 2'd0) begin
                            nospace = 1'b1;
                        end else begin
                            // close the options area with OVERLOAD and END
                            res_o[n] = byte_write(cur, CODE_OVERLOAD);
                            n = n + 1'b1;
                            cur = cur + 16'd1;
                            res_o[n] = byte_write(cur, 8'd1);
                            n = n + 1'b1;
                            cur = cur + 16'd1;
                            res_o[n] = byte_write(cur, {6'd0, ov});
                            n = n + 1'b1;
                            cur = cur + 16'd1;
                            res_o[n] = byte_write(cur, CODE_END);
                            n = n + 1'b1;
                            if (ov[0]) begin
                                res_o[n] = byte_write(FILE_START, CODE_END);
                                n = n + 1'b1;
                            end
                            if (ov[1]) begin
                                res_o[n] = byte_write(SNAME_START, CODE_END);
                                n = n + 1'b1;
                            end
                            if (ov[0]) begin
                                cur  = FILE_START;
                                area = AREA_FILE;
                            end else begin
                                cur  = SNAME_START;
                                area = AREA_SNAME;
                            end
                        end
                    end
                    if (!fit && !nospace && area == AREA_FILE) begin
                        if (area_fits(cur, FILE_START, FILE_SIZE, item_i.data_length)) begin
                            fit = 1'b1;
                        end else if (ov[1]) begin
                            cur  = SNAME_START;
                            area = AREA_SNAME;
                        end else begin
                            nospace = 1'b1;
                        end
                    end
                    if (!fit && !nospace && area[1]) begin
                        if (area_fits(cur, SNAME_START, SNAME_SIZE, item_i.data_length)) begin
                            fit = 1'b1;
                        end else begin
                            nospace = 1'b1;
                        end
                    end

                    left = item_i.data_length;
                    if (fit) begin
                        rej = 1'b0;
                        res_o[n] = byte_write(cur, item_i.option_code);
                        n = n + 1'b1;
                        cur = cur + 16'd1;
                        res_o[n] = byte_write(cur, item_i.data_length);
                        n = n + 1'b1;
                        cur = cur + 16'd1;
                        if (item_i.data_length == 8'd0) begin
                            res_o[n] = byte_write(cur, CODE_END);
                            n = n + 1'b1;
                        end
                    end else begin
                        rej = 1'b1;
                        res_o[n] = no_write(ST_NO_SPACE);
                        n = n + 1'b1;
                    end
                end
            end
            OP_DATA: begin
                if (left == 8'd0) begin
                    res_o[0] = no_write(ST_DROPPED);
                    n = RES_CNT_W'(1);
                end else if (rej) begin
                    left = left - 8'd1;
                    res_o[0] = no_write(ST_DROPPED);
                    n = RES_CNT_W'(1);
                end else begin
                    res_o[0] = byte_write(cur, item_i.data_byte);
                    cur  = cur + 16'd1;
                    left = left - 8'd1;
                    n = RES_CNT_W'(1);
                    if (left == 8'd0) begin
                        res_o[1] = byte_write(cur, CODE_END);
                        n = RES_CNT_W'(2);
                    end
                end
            end
            default: begin
                // unused operation: no result, state untouched
            end
        endcase

        count_o          = n;
        state_o.cursor     = cur;
        state_o.area       = area;
        state_o.bytes_left = left;
        state_o.rejected   = rej;
    end

endmodule

### rtl/dop_checker.sv
`timescale 1ns / 1ps

module dop_checker import dop_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // A stalled result holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Nothing is offered in the cycle after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result offered right after reset");

    // A report without a write carries zero address and value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.write_valid |->
            m_data.write_address == 16'd0 && m_data.write_value == 8'd0)
        else $error("non-writing result carries address or value");

    // Writes always report ok; any error report ends its item's run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> !m_data.write_valid && m_data.last_of_run)
        else $error("error report is a write or not the last of its run");

    // The input is held back only while results are waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |-> m_valid)
        else $error("input stalled with no result pending");

endmodule

bind dhcp_option_placer_unit dop_checker u_dop_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

### tb/tb_dhcp_option_placer_unit.sv
`timescale 1ns / 1ps

module tb_dhcp_option_placer_unit;
    import dop_pkg::*;

    // Build parameters of the placer; the predictor uses the same values.
    localparam int MIN_PKT_SIZE = 576;
    localparam int HDR_RESERVE  = 68;

    // Operation code that the block takes and then ignores.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int MAX_WAIT      = 18;     // longest gap or stall per transfer
    localparam int SETTLE_CYCLES = 8;      // block latency plus margin
    localparam int PHASE_ITEMS   = 72;     // random items per configuration
    localparam int NUM_PHASES    = 6;
    // Worst case per item is a full gap plus nine results each behind a full stall;
    // allow roughly four times that for ~460 items.
    localparam int RUN_LIMIT     = 400000;

    // One row of the directed part: the item, plus a status typed in by hand
    // where the single result of the item is obvious.
    typedef struct packed {
        in_item_t   item;
        logic       fixed;
        logic [1:0] want_status;
    } stim_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_item_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_item_t   m_data;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = REG_MAX_PACKET_SIZE;
    logic [15:0] cfg_wdata = '0;

    // Placement state and register copies kept by the predictor.
    logic [15:0] cur_addr   = OPT_START;
    logic [1:0]  cur_area   = AREA_OPTIONS;
    logic [7:0]  owed_bytes = '0;
    logic        dropping   = 1'b0;
    logic [15:0] pkt_size   = '0;
    logic [1:0]  ovl_sel    = '0;

    out_item_t   item_writes[$];      // results of the item being predicted
    out_item_t   pending_writes[$];   // results still owed by the block
    stim_row_t   directed_rows[$];

    int          mismatches  = 0;
    int          items_sent  = 0;
    int          cycle_count = 0;
    int          rx_hold     = 0;
    bit          tx_quiet    = 1'b0;
    bit          rx_quiet    = 1'b0;

    always #2 aclk = ~aclk;

    dhcp_option_placer_unit #(
        .MIN_PACKET_SIZE(MIN_PKT_SIZE),
        .HEADER_RESERVE (HDR_RESERVE)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Placement predictor
    // ------------------------------------------------------------------

    function automatic out_item_t make_res(input logic wv, input logic [15:0] addr,
                                           input logic [7:0] val, input logic [1:0] st);
        out_item_t r;
        r.write_valid   = wv;
        r.write_address = addr;
        r.write_value   = val;
        r.status        = st;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    // Bytes left in an overflow area from the cursor on; zero outside it.
    function automatic int room_in(input int start, input int size);
        int offset;
        offset = int'(cur_addr) - start;
        if (offset < 0 || offset >= size)
            return 0;
        return size - offset;
    endfunction

    task automatic post_write(input logic [15:0] addr, input logic [7:0] val);
        item_writes.push_back(make_res(1'b1, addr, val, ST_OK));
    endtask

    // Store at the cursor and advance it.
    task automatic put_byte(input logic [7:0] val);
        post_write(cur_addr, val);
        cur_addr = cur_addr + 16'd1;
    endtask

    task automatic report(input logic [1:0] st);
        item_writes.push_back(make_res(1'b0, 16'd0, 8'd0, st));
    endtask

    task automatic forecast_placement(input in_item_t it);
        int        lim;
        int        room;
        int        len;
        bit        fit;
        bit        full;
        out_item_t r;
        item_writes.delete();
        len = int'(it.data_length);
        case (it.operation)
            OP_BEGIN: begin
                cur_addr   = OPT_START;
                cur_area   = AREA_OPTIONS;
                owed_bytes = '0;
                dropping   = 1'b0;
                post_write(COOKIE_ADDR,         COOKIE_0);
                post_write(COOKIE_ADDR + 16'd1, COOKIE_1);
                post_write(COOKIE_ADDR + 16'd2, COOKIE_2);
                post_write(COOKIE_ADDR + 16'd3, COOKIE_3);
                post_write(OPT_START, CODE_END);
            end
            OP_HEADER: begin
                if (it.option_code == CODE_PAD || it.option_code == CODE_OVERLOAD ||
                    it.option_code == CODE_END) begin
                    dropping   = 1'b1;
                    owed_bytes = it.data_length;
                    report(ST_INVALID);
                end else begin
                    fit  = 1'b0;
                    full = 1'b0;
                    if (cur_area == AREA_OPTIONS) begin
                        lim  = (int'(pkt_size) > MIN_PKT_SIZE) ? int'(pkt_size) - HDR_RESERVE
                                                               : MIN_PKT_SIZE - HDR_RESERVE;
                        room = (lim > int'(cur_addr)) ? lim - int'(cur_addr) : 0;
                        if (room >= len + int'(OPT_AREA_RESERVE)) begin
                            fit = 1'b1;
                        end else if (ovl_sel == 2'd0) begin
                            full = 1'b1;
                        end else begin
                            // Close the options area with an OVERLOAD option.
                            put_byte(CODE_OVERLOAD);
                            put_byte(8'd1);
                            put_byte({6'd0, ovl_sel});
                            post_write(cur_addr, CODE_END);
                            if (ovl_sel[0])
                                post_write(FILE_START, CODE_END);
                            if (ovl_sel[1])
                                post_write(SNAME_START, CODE_END);
                            if (ovl_sel[0]) begin
                                cur_addr = FILE_START;
                                cur_area = AREA_FILE;
                            end else begin
                                cur_addr = SNAME_START;
                                cur_area = AREA_SNAME;
                            end
                        end
                    end
                    if (!fit && !full && cur_area == AREA_FILE) begin
                        if (room_in(int'(FILE_START), int'(FILE_SIZE)) >=
                                len + int'(OVL_AREA_RESERVE)) begin
                            fit = 1'b1;
                        end else if (ovl_sel[1]) begin
                            cur_addr = SNAME_START;
                            cur_area = AREA_SNAME;
                        end else begin
                            full = 1'b1;
                        end
                    end
                    // The unused fourth area code falls in here as well.
                    if (!fit && !full && cur_area >= AREA_SNAME) begin
                        if (room_in(int'(SNAME_START), int'(SNAME_SIZE)) >=
                                len + int'(OVL_AREA_RESERVE))
                            fit = 1'b1;
                        else
                            full = 1'b1;
                    end
                    owed_bytes = it.data_length;
                    if (fit) begin
                        dropping = 1'b0;
                        put_byte(it.option_code);
                        put_byte(it.data_length);
                        if (len == 0)
                            post_write(cur_addr, CODE_END);
                    end else begin
                        dropping = 1'b1;
                        report(ST_NO_SPACE);
                    end
                end
            end
            OP_DATA: begin
                if (owed_bytes == 8'd0) begin
                    report(ST_DROPPED);
                end else if (dropping) begin
                    owed_bytes = owed_bytes - 8'd1;
                    report(ST_DROPPED);
                end else begin
                    put_byte(it.data_byte);
                    owed_bytes = owed_bytes - 8'd1;
                    if (owed_bytes == 8'd0)
                        post_write(cur_addr, CODE_END);
                end
            end
            default: begin
            end
        endcase
        // Flag the final result of the item.
        if (item_writes.size() > 0) begin
            r = item_writes.pop_back();
            r.last_of_run = 1'b1;
            item_writes.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    function automatic in_item_t rand_item(input logic [1:0] op);
        in_item_t it;
        it.operation   = op;
        it.option_code = 8'($urandom_range(0, 255));
        it.data_length = 8'($urandom_range(0, 255));
        it.data_byte   = 8'($urandom_range(0, 255));
        return it;
    endfunction

    // Present one item, hold it until the transfer, then queue its results:
    // the hand-typed one where the row carries it, else the predicted ones.
    task automatic send_item(input in_item_t it, input logic fixed,
                             input logic [1:0] want_status);
        int        gap;
        out_item_t r;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
        if ($urandom_range(0, 29) == 0)
            tx_quiet = !tx_quiet;
        // Drop valid only when a gap follows, so valid is never lowered and
        // raised again in one step.
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        forecast_placement(it);
        if (fixed) begin
            r = make_res(1'b0, 16'd0, 8'd0, want_status);
            r.last_of_run = 1'b1;
            pending_writes.push_back(r);
        end else begin
            foreach (item_writes[i])
                pending_writes.push_back(item_writes[i]);
        end
        if (it.operation != OP_UNUSED)
            items_sent++;
    endtask

    // Hold the sender until every owed result has arrived, then let the
    // block settle in case an item with no result is still in flight.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write both registers on back-to-back edges; call only when idle.
    task automatic set_limits(input logic [15:0] mps, input logic [1:0] ov);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MAX_PACKET_SIZE;
        cfg_wdata <= mps;
        @(posedge aclk);
        cfg_index <= REG_OVERLOAD_SECTIONS;
        cfg_wdata <= {14'd0, ov};
        @(posedge aclk);
        cfg_we    <= 1'b0;
        pkt_size  = mps;
        ovl_sel   = ov;
    endtask

    task automatic add_row(input logic [1:0] op, input logic [7:0] code,
                           input logic [7:0] len, input logic [7:0] dval,
                           input logic fixed, input logic [1:0] want_status);
        stim_row_t row;
        row.item.operation   = op;
        row.item.option_code = code;
        row.item.data_length = len;
        row.item.data_byte   = dval;
        row.fixed            = fixed;
        row.want_status      = want_status;
        directed_rows.push_back(row);
    endtask

    // Mostly well-formed options with random content; the rest is begin-messages,
    // early headers with any length, rejected codes, stray data and ignored items.
    task automatic random_sequence();
        in_item_t it;
        int       pick;
        int       n;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            send_item(rand_item(OP_BEGIN), 1'b0, ST_OK);
        end else if (pick < 84) begin
            it = rand_item(OP_HEADER);
            do
                it.option_code = 8'($urandom_range(1, 254));
            while (it.option_code == CODE_OVERLOAD);
            if (pick < 64) begin
                // Complete option, mostly short so the areas fill up often.
                if ($urandom_range(0, 9) == 0)
                    it.data_length = 8'($urandom_range(11, 40));
                else
                    it.data_length = 8'($urandom_range(0, 10));
                n = int'(it.data_length);
            end else begin
                // Random length probes the fit checks; cut it short.
                n = $urandom_range(0, 3);
            end
            send_item(it, 1'b0, ST_OK);
            repeat (n) send_item(rand_item(OP_DATA), 1'b0, ST_OK);
        end else if (pick < 92) begin
            it = rand_item(OP_HEADER);
            case ($urandom_range(0, 2))
                0:       it.option_code = CODE_PAD;
                1:       it.option_code = CODE_OVERLOAD;
                default: it.option_code = CODE_END;
            endcase
            it.data_length = 8'($urandom_range(0, 6));
            send_item(it, 1'b0, ST_OK);
            repeat (it.data_length) send_item(rand_item(OP_DATA), 1'b0, ST_OK);
        end else if (pick < 97) begin
            send_item(rand_item(OP_DATA), 1'b0, ST_OK);
        end else begin
            send_item(rand_item(OP_UNUSED), 1'b0, ST_OK);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial begin : stimulus
        int p;
        int target;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Registers still at reset: limit 508, no overload. Cursor at 240.
        add_row(OP_HEADER, CODE_PAD,      8'd3,   8'hFF, 1'b1, ST_INVALID);
        add_row(OP_DATA,   8'h00,         8'h00,  8'hFF, 1'b1, ST_DROPPED);
        add_row(OP_DATA,   8'hFF,         8'hFF,  8'h00, 1'b1, ST_DROPPED);
        add_row(OP_DATA,   8'h00,         8'h00,  8'hA5, 1'b1, ST_DROPPED);
        // Nothing owed any more: stray data.
        add_row(OP_DATA,   8'h00,         8'h00,  8'h5A, 1'b1, ST_DROPPED);
        add_row(OP_HEADER, CODE_OVERLOAD, 8'd0,   8'h00, 1'b1, ST_INVALID);
        add_row(OP_HEADER, CODE_END,      8'd255, 8'h00, 1'b1, ST_INVALID);
        // Header while 255 bytes are still owed; zero length adds END at once.
        add_row(OP_HEADER, 8'd1,          8'd0,   8'h00, 1'b0, ST_OK);
        add_row(OP_UNUSED, 8'hFF,         8'hFF,  8'hFF, 1'b0, ST_OK);
        add_row(OP_HEADER, 8'd254,        8'd2,   8'h00, 1'b0, ST_OK);
        add_row(OP_DATA,   8'h00,         8'h00,  8'h00, 1'b0, ST_OK);
        add_row(OP_DATA,   8'h00,         8'h00,  8'hFF, 1'b0, ST_OK);
        add_row(OP_HEADER, 8'h7F,         8'd1,   8'h00, 1'b0, ST_OK);
        add_row(OP_DATA,   8'h00,         8'h00,  8'h3C, 1'b0, ST_OK);
        // 259 bytes left: length 255 does not fit and overload is off.
        add_row(OP_HEADER, 8'h80,         8'd255, 8'h00, 1'b1, ST_NO_SPACE);
        add_row(OP_DATA,   8'h00,         8'h00,  8'h11, 1'b1, ST_DROPPED);
        // Exactly fits: 253 + 6 = 259.
        add_row(OP_HEADER, 8'h40,         8'd253, 8'h00, 1'b0, ST_OK);
        add_row(OP_DATA,   8'h00,         8'h00,  8'h01, 1'b0, ST_OK);
        add_row(OP_HEADER, 8'h41,         8'd254, 8'h00, 1'b1, ST_NO_SPACE);
        add_row(OP_DATA,   8'h00,         8'h00,  8'h80, 1'b1, ST_DROPPED);
        add_row(OP_BEGIN,  8'hAA,         8'h55,  8'hCC, 1'b0, ST_OK);
        add_row(OP_HEADER, 8'd3,          8'd0,   8'h00, 1'b0, ST_OK);
        add_row(OP_DATA,   8'h00,         8'h00,  8'h7E, 1'b1, ST_DROPPED);

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].fixed,
                      directed_rows[i].want_status);

        // Walk the register settings; placement state carries over phases.
        for (p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            case (p)
                0:       set_limits(16'd577,   2'd3);
                1:       set_limits(16'd0,     2'd1);
                2:       set_limits(16'd576,   2'd2);   // sname only
                3:       set_limits(16'd65535, 2'd3);
                4:       set_limits(16'd700,   2'd0);
                default: set_limits(16'd600,   2'd3);
            endcase
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                // Now and then drain the block completely before going on.
                if ($urandom_range(0, 24) == 0)
                    wait_idle();
                random_sequence();
            end
        end

        wait_idle();
        if (mismatches == 0 && pending_writes.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: stall at random, check each transfer in order
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : result_side
        out_item_t want;
        int        draw;
        if (aresetn && m_valid && m_ready) begin
            if (pending_writes.size() == 0) begin
                $display("%0t ns: unexpected result %h", $time, m_data);
                mismatches++;
            end else begin
                want = pending_writes.pop_front();
                check_field("write_valid",   16'(want.write_valid),   16'(m_data.write_valid));
                check_field("write_address", want.write_address,      m_data.write_address);
                check_field("write_value",   16'(want.write_value),   16'(m_data.write_value));
                check_field("status",        16'(want.status),        16'(m_data.status));
                check_field("last_of_run",   16'(want.last_of_run),   16'(m_data.last_of_run));
            end
            // Draw the stall before the next transfer; quiet stretches skip it.
            draw = rx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            if ($urandom_range(0, 39) == 0)
                rx_quiet <= !rx_quiet;
            if (draw > 0) begin
                m_ready <= 1'b0;
                rx_hold <= draw;
            end
        end else if (!m_ready) begin
            if (rx_hold <= 1)
                m_ready <= 1'b1;
            else
                rx_hold <= rx_hold - 1;
        end
    end

    // Watchdog: end the run if the block stops making progress.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("%0t ns: timeout, %0d results still owed", $time, pending_writes.size());
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
